[src/bmoc_pkg.sv]
// Shared types, constants and a row function for the binary morphology filter.
package bmoc_pkg;

  localparam int unsigned RowW = 64;
  localparam int unsigned MaxWidth = 64;
  localparam int unsigned HistDepth = 4;
  localparam int unsigned NumStages = 4;
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW = $clog2(QDepth);
  localparam int unsigned QCntW = $clog2(QDepth + 1);
  localparam int unsigned FillW = $clog2(HistDepth + 1);
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;
  localparam int unsigned WidthW = 7;
  localparam int unsigned RadiusW = 2;

  localparam logic [WidthW-1:0] WidthRst = WidthW'(MaxWidth);
  localparam logic [RadiusW-1:0] RadiusRst = RadiusW'(1);

  localparam logic RegImageWidth = 1'b0;
  localparam logic RegWindowRadius = 1'b1;

  typedef struct packed {
    logic [RowW-1:0] row;
    logic            fin;
  } bmoc_item_t;

  typedef struct packed {
    logic [RowW-1:0] mask;
    logic            rad2;
  } bmoc_cfg_t;

  function automatic logic [RowW-1:0] bmoc_horiz(input logic [RowW-1:0] x,
                                                 input logic rad2,
                                                 input logic dilate,
                                                 input logic [RowW-1:0] mask);
    logic [RowW-1:0] near;
    logic [RowW-1:0] far;
    logic [RowW-1:0] acc;
    if (dilate) begin
      near = (x << 1) | (x >> 1);
      far  = rad2 ? ((x << 2) | (x >> 2)) : '0;
      acc  = x | near | far;
    end else begin
      near = (x << 1) & (x >> 1);
      far  = rad2 ? ((x << 2) & (x >> 2)) : '1;
      acc  = x & near & far;
    end
    return acc & mask;
  endfunction

endpackage

[src/bmoc_front.sv]
// Front end: configuration registers, input acceptance and row masking.
module bmoc_front import bmoc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [RowW-1:0]     s_axis_tdata,
  input  logic                s_axis_tlast,
  output logic                q_valid_o,
  input  logic                q_ready_i,
  output bmoc_item_t          q_item_o,
  output bmoc_cfg_t           cfg_o
);

  logic [WidthW-1:0]  width_q, width_d;
  logic [RadiusW-1:0] radius_q, radius_d;
  logic [RowW-1:0]    mask_q, mask_d;
  logic               wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    width_d  = width_q;
    radius_d = radius_q;
    mask_d   = mask_q;
    if (wr_en && (paddr[2] == RegImageWidth)) begin
      width_d = pwdata[WidthW-1:0];
      if (width_d >= WidthW'(MaxWidth)) begin
        mask_d = '1;
      end else begin
        mask_d = (RowW'(1) << width_d[$clog2(RowW)-1:0]) - RowW'(1);
      end
    end
    if (wr_en && (paddr[2] == RegWindowRadius)) begin
      radius_d = pwdata[RadiusW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthRst;
      radius_q <= RadiusRst;
      mask_q   <= '1;
    end else begin
      width_q  <= width_d;
      radius_q <= radius_d;
      mask_q   <= mask_d;
    end
  end

  assign prdata = (paddr[2] == RegWindowRadius) ? ApbDataW'(radius_q) : ApbDataW'(width_q);

  assign cfg_o.mask = mask_q;
  assign cfg_o.rad2 = radius_q[1];

  assign s_axis_tready = q_ready_i;
  assign q_valid_o     = s_axis_tvalid;
  assign q_item_o.row  = s_axis_tdata & mask_q;
  assign q_item_o.fin  = s_axis_tlast;

endmodule

[src/bmoc_queue.sv]
// Short queue of accepted rows between the front end and the filter stages.
module bmoc_queue import bmoc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  bmoc_item_t in_item_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output bmoc_item_t out_item_o
);

  bmoc_item_t         mem_q [QDepth];
  logic [QPtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]   count_q, count_d;
  logic               push;
  logic               pop;

  assign in_ready_o  = (count_q != QCntW'(QDepth));
  assign out_valid_o = (count_q != '0);
  assign out_item_o  = mem_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + QPtrW'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + QPtrW'(1) : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + QCntW'(1);
    end else if (pop && !push) begin
      count_d = count_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_item_i;
    end
  end

endmodule

[src/bmoc_stage.sv]
// One square-window erosion or dilation stage with its own row history and flush.
module bmoc_stage import bmoc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       dilate_i,
  input  bmoc_cfg_t  cfg_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  bmoc_item_t in_item_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output bmoc_item_t out_item_o
);

  logic [RowW-1:0]  hist_q [HistDepth];
  logic [RowW-1:0]  hist_d [HistDepth];
  logic [FillW-1:0] fill_q, fill_d;
  logic             flush_q, flush_d;
  logic             kcnt_q, kcnt_d;
  logic             pend_full_q, pend_full_d;
  logic             out_valid_q, out_valid_d;
  bmoc_item_t       out_item_q, out_item_d;

  logic             slot_free;
  logic             take;
  logic             push;
  logic             last_k;
  logic             emit;
  logic [RowW-1:0]  x;
  logic [RowW-1:0]  win;
  logic [RowW-1:0]  hz_x;
  logic [RowW-1:0]  hz [HistDepth];
  logic [FillW-1:0] fill_inc;
  logic [FillW-1:0] r_fill;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = slot_free && !flush_q;
  assign take       = in_valid_i && in_ready_o;
  assign push       = take || (flush_q && slot_free);
  assign x          = flush_q ? '0 : in_item_i.row;
  assign last_k     = !cfg_i.rad2 || kcnt_q;
  assign r_fill     = cfg_i.rad2 ? FillW'(2) : FillW'(1);
  assign fill_inc   = (fill_q == FillW'(HistDepth)) ? fill_q : fill_q + FillW'(1);
  assign emit       = flush_q ? (last_k || pend_full_q) : (fill_q >= r_fill);

  always_comb begin
    hz_x = bmoc_horiz(x, cfg_i.rad2, dilate_i, cfg_i.mask);
    for (int i = 0; i < HistDepth; i++) begin
      hz[i] = bmoc_horiz(hist_q[i], cfg_i.rad2, dilate_i, cfg_i.mask);
    end
    if (dilate_i) begin
      win = hz_x | hz[0] | hz[1] | (cfg_i.rad2 ? (hz[2] | hz[3]) : '0);
    end else begin
      win = hz_x & hz[0] & hz[1] & (cfg_i.rad2 ? (hz[2] & hz[3]) : '1);
    end
    win = win & cfg_i.mask;
  end

  always_comb begin
    hist_d      = hist_q;
    fill_d      = fill_q;
    flush_d     = flush_q;
    kcnt_d      = kcnt_q;
    pend_full_d = pend_full_q;
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    if (push) begin
      for (int i = HistDepth - 1; i > 0; i--) begin
        hist_d[i] = hist_q[i-1];
      end
      hist_d[0] = x & cfg_i.mask;
      if (flush_q) begin
        if (last_k) begin
          for (int i = 0; i < HistDepth; i++) begin
            hist_d[i] = '0;
          end
          fill_d  = '0;
          flush_d = 1'b0;
        end else begin
          kcnt_d = 1'b1;
        end
      end else begin
        fill_d = fill_inc;
        if (in_item_i.fin) begin
          flush_d     = 1'b1;
          kcnt_d      = 1'b0;
          pend_full_d = (fill_inc >= FillW'(2));
        end
      end
    end
    if (slot_free) begin
      out_valid_d    = push && emit;
      out_item_d.row = win;
      out_item_d.fin = flush_q && last_k;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < HistDepth; i++) begin
        hist_q[i] <= '0;
      end
      fill_q      <= '0;
      flush_q     <= 1'b0;
      kcnt_q      <= 1'b0;
      pend_full_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      hist_q      <= hist_d;
      fill_q      <= fill_d;
      flush_q     <= flush_d;
      kcnt_q      <= kcnt_d;
      pend_full_q <= pend_full_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  a_fill_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(HistDepth))
    else $error("fill count beyond history depth");

  a_flush_after_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(flush_q) |-> $past(take && in_item_i.fin))
    else $error("flush started without a final row");

  a_flush_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (flush_q && slot_free && last_k) |=> (!flush_q && fill_q == '0 && out_valid_q
                                          && out_item_q.fin))
    else $error("flush end did not clear history or mark the last row");

endmodule

[src/binary_morph_open_close_top.sv]
// Top level of the binary opening-then-closing row filter.
//
// Rows enter on the s_axis channel, one row of up to 64 pixels per beat, with
// tlast on the final row of a frame. Filtered rows leave on the m_axis channel
// in the same order; tlast marks the last filtered row of the frame, and every
// frame of N rows gives exactly N output beats. The APB port sets the image
// width (byte address 0) and the window radius (byte address 4); write them
// only while no frame is in flight.
// An accepted row passes a four-entry queue and then the four stage registers
// in order before its result reaches m_axis. Results lag the input by 4 rows
// per unit of radius. Throughput is one row per cycle while m_axis does not
// stall. A final row makes each stage insert one flush row per unit of radius,
// which holds that stage's input while the tail of the frame drains.
// Reset clears all row histories and restores width 64 and radius 1.
// When the receiver stalls, the output register holds its beat and back
// pressure reaches the input once the stages and the queue are full.
module binary_morph_open_close_top import bmoc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [RowW-1:0]     s_axis_tdata,  // row_bits
  input  logic                s_axis_tlast,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [RowW-1:0]     m_axis_tdata,  // filtered_row
  output logic                m_axis_tlast
);

  bmoc_cfg_t  cfg;
  logic       fq_valid;
  logic       fq_ready;
  bmoc_item_t fq_item;
  logic       st_valid [NumStages+1];
  logic       st_ready [NumStages+1];
  bmoc_item_t st_item  [NumStages+1];

  bmoc_front u_front (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tlast,
    .q_valid_o (fq_valid),
    .q_ready_i (fq_ready),
    .q_item_o  (fq_item),
    .cfg_o     (cfg)
  );

  bmoc_queue u_queue (
    .clk_i,
    .rst_ni,
    .in_valid_i  (fq_valid),
    .in_ready_o  (fq_ready),
    .in_item_i   (fq_item),
    .out_valid_o (st_valid[0]),
    .out_ready_i (st_ready[0]),
    .out_item_o  (st_item[0])
  );

  for (genvar s = 0; s < NumStages; s++) begin : g_stage
    bmoc_stage u_stage (
      .clk_i,
      .rst_ni,
      .dilate_i    ((s == 1) || (s == 2)),
      .cfg_i       (cfg),
      .in_valid_i  (st_valid[s]),
      .in_ready_o  (st_ready[s]),
      .in_item_i   (st_item[s]),
      .out_valid_o (st_valid[s+1]),
      .out_ready_i (st_ready[s+1]),
      .out_item_o  (st_item[s+1])
    );
  end

  assign m_axis_tvalid         = st_valid[NumStages];
  assign st_ready[NumStages]   = m_axis_tready;
  assign m_axis_tdata          = st_item[NumStages].row;
  assign m_axis_tlast          = st_item[NumStages].fin;

endmodule
